>>> src/ils_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store package
// Command and status codes, request and result types, and the control
// bundle passed from the command decoder to the slot datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam logic [3:0] CMD_PUSH_BACK  = 4'd0;
    localparam logic [3:0] CMD_PUSH_FRONT = 4'd1;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
    localparam logic [3:0] CMD_POP_BACK   = 4'd3;
    localparam logic [3:0] CMD_GET        = 4'd4;
    localparam logic [3:0] CMD_SET        = 4'd5;
    localparam logic [3:0] CMD_INSERT     = 4'd6;
    localparam logic [3:0] CMD_REMOVE     = 4'd7;
    localparam logic [3:0] CMD_CLEAR      = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_OOB   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // What happens to the slot array for one request.
    typedef enum logic [1:0] {
        SOP_NONE  = 2'd0,
        SOP_OPEN  = 2'd1,
        SOP_CLOSE = 2'd2,
        SOP_WRITE = 2'd3
    } slot_op_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [4:0]  position;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [4:0]  occupancy;
        logic        is_empty;
        logic        error_seen;
    } out_item_t;

    typedef struct packed {
        slot_op_t   op;
        logic       read_en;
        logic [1:0] status;
    } ctrl_t;

endpackage

>>> src/ils_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store command decoder
// Checks a request against the current count and works out the slot
// operation, the slot index it acts on, the status and the new count.
// ----------------------------------------------------------------------------
module ils_ctrl
    import ils_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic [3:0]                      command,
    input  logic [4:0]                      position,
    input  logic [$clog2(CAPACITY+1)-1:0]   count,
    output ctrl_t                           ctrl,
    output logic [$clog2(CAPACITY)-1:0]     at_idx,
    output logic [$clog2(CAPACITY+1)-1:0]   count_next
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_w;
    logic [CW-1:0]   cnt_inc;
    logic [CW-1:0]   cnt_dec;
    logic            full;
    logic            empty;

    assign pos_w   = CMPW'(position);
    assign cnt_w   = CMPW'(count);
    assign cnt_inc = count + CW'(1);
    assign cnt_dec = count - CW'(1);
    assign full    = (count == CW'(CAPACITY));
    assign empty   = (count == '0);

    always_comb
    begin
        ctrl.op      = SOP_NONE;
        ctrl.read_en = 1'b0;
        ctrl.status  = ST_OK;
        at_idx       = '0;
        count_next   = count;
        unique case (command)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    ctrl.status = ST_FULL;
                end
                else
                begin
                    ctrl.op    = SOP_OPEN;
                    at_idx     = (command == CMD_PUSH_BACK) ? IW'(count) : '0;
                    count_next = cnt_inc;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (empty)
                begin
                    ctrl.status = ST_EMPTY;
                end
                else
                begin
                    ctrl.op      = SOP_CLOSE;
                    ctrl.read_en = 1'b1;
                    at_idx       = (command == CMD_POP_BACK) ? IW'(cnt_dec) : '0;
                    count_next   = cnt_dec;
                end
            end
            CMD_GET, CMD_SET, CMD_REMOVE:
            begin
                if (pos_w >= cnt_w)
                begin
                    ctrl.status = ST_OOB;
                end
                else
                begin
                    at_idx = IW'(pos_w);
                    if (command == CMD_GET)
                    begin
                        ctrl.read_en = 1'b1;
                    end
                    else if (command == CMD_SET)
                    begin
                        ctrl.op = SOP_WRITE;
                    end
                    else
                    begin
                        ctrl.op    = SOP_CLOSE;
                        count_next = cnt_dec;
                    end
                end
            end
            CMD_INSERT:
            begin
                // The index check takes precedence over the full check.
                if (pos_w > cnt_w)
                begin
                    ctrl.status = ST_OOB;
                end
                else if (full)
                begin
                    ctrl.status = ST_FULL;
                end
                else
                begin
                    ctrl.op    = SOP_OPEN;
                    at_idx     = IW'(pos_w);
                    count_next = cnt_inc;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count;
            end
        endcase
    end

endmodule

>>> src/indexed_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store
// Bounded ordered list of data words with push, pop, get, set, insert,
// remove and clear requests, each answered by one result.
// ----------------------------------------------------------------------------
// One request is accepted per clock cycle and its result appears in the
// output register on the following cycle; while a result waits, a new
// request is taken only in the same cycle as it is taken. All slots
// shift in parallel through one multiplexer per slot, so an insert or
// remove at any index is done on acceptance. Rejected requests leave the
// list as it was, and the most recent error stays recorded until reset.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int IW      = $clog2(CAPACITY);
    localparam int OCCW    = (CW > 5) ? CW : 5;
    localparam int STORE_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    logic [STORE_W-1:0] slots_reg [CAPACITY];
    logic [STORE_W-1:0] slots_next [CAPACITY];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [1:0]         last_error_reg;
    logic [1:0]         last_error_next;
    logic               out_valid_reg;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;

    ctrl_t              ctrl;
    logic [IW-1:0]      at_idx;
    logic               accept;
    logic [STORE_W-1:0] wr_word;
    logic [31:0]        rd_word;
    logic [OCCW-1:0]    occ_w;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign wr_word   = in_item.value[STORE_W-1:0];

    ils_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .command    (in_item.command),
        .position   (in_item.position),
        .count      (count_reg),
        .ctrl       (ctrl),
        .at_idx     (at_idx),
        .count_next (count_next)
    );

    // Per-slot selection: shift up behind an opened gap, shift down over a
    // closed one, or load the request word at the chosen index.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_slot
        localparam logic [IW-1:0] K = IW'(k);
        logic [STORE_W-1:0] below;
        logic [STORE_W-1:0] above;

        if (k > 0)
        begin : g_below
            assign below = slots_reg[k-1];
        end
        else
        begin : g_no_below
            assign below = slots_reg[k];
        end

        if (k < CAPACITY - 1)
        begin : g_above
            assign above = slots_reg[k+1];
        end
        else
        begin : g_no_above
            assign above = slots_reg[k];
        end

        always_comb
        begin
            slots_next[k] = slots_reg[k];
            case (ctrl.op)
                SOP_OPEN:
                begin
                    if (K == at_idx)
                    begin
                        slots_next[k] = wr_word;
                    end
                    else if (K > at_idx)
                    begin
                        slots_next[k] = below;
                    end
                end
                SOP_CLOSE:
                begin
                    if (K >= at_idx)
                    begin
                        slots_next[k] = above;
                    end
                end
                SOP_WRITE:
                begin
                    if (K == at_idx)
                    begin
                        slots_next[k] = wr_word;
                    end
                end
                default:
                begin
                    slots_next[k] = slots_reg[k];
                end
            endcase
        end
    end

    always_comb
    begin
        rd_word = '0;
        if (ctrl.read_en)
        begin
            rd_word[STORE_W-1:0] = slots_reg[at_idx];
        end
    end

    assign last_error_next = (ctrl.status != ST_OK) ? ctrl.status : last_error_reg;
    assign occ_w           = OCCW'(count_next);

    always_comb
    begin
        out_item_next.read_value = rd_word;
        out_item_next.status     = ctrl.status;
        out_item_next.occupancy  = occ_w[4:0];
        out_item_next.is_empty   = (count_next == '0);
        out_item_next.error_seen = (last_error_next != ST_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            last_error_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg      <= count_next;
                last_error_reg <= last_error_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                slots_reg[i] <= slots_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list count exceeds capacity");

    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ctrl.status != ST_OK |=> $stable(count_reg))
        else $error("rejected request changed the count");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.status != ST_OK |-> out_item_reg.error_seen)
        else $error("failed request does not report a recorded error");

    a_error_held: assert property (@(posedge clk) disable iff (!rst_n)
        last_error_reg != ST_OK |=> last_error_reg != ST_OK)
        else $error("recorded error was cleared");

    a_read_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.status != ST_OK |-> out_item_reg.read_value == '0)
        else $error("failed request returned a data word");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store testbench
// Sends directed and random list requests through the valid/ready ports
// while a shadow copy of the list predicts every result. Each result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import ils_pkg::*;

    localparam int DEPTH           = 16;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_REQUESTS = 1750;

    localparam int TREND_MIXED  = 0;
    localparam int TREND_GROW   = 1;
    localparam int TREND_SHRINK = 2;

    // Shadow copy of the list, and the results that are still owed by the block.
    class list_shadow;
        logic [31:0] slots [DEPTH];
        int unsigned fill;
        logic [1:0]  last_error;
        out_item_t   expected_results [$];
        int unsigned errors;

        function new();
            fill       = 0;
            last_error = ST_OK;
            errors     = 0;
        endfunction

        function void open_gap(int unsigned at, logic [31:0] word);
            int unsigned k;
            for (k = fill; k > at; k--)
                slots[k] = slots[k - 1];
            slots[at] = word;
            fill++;
        endfunction

        function logic [31:0] close_gap(int unsigned at);
            logic [31:0] word;
            int unsigned k;
            word = slots[at];
            for (k = at; k + 1 < fill; k++)
                slots[k] = slots[k + 1];
            fill--;
            return word;
        endfunction

        function void apply_request(in_item_t req);
            out_item_t res;
            res = '0;
            case (req.command)
                CMD_PUSH_BACK, CMD_PUSH_FRONT:
                begin
                    if (fill >= DEPTH)
                        res.status = ST_FULL;
                    else
                        open_gap((req.command == CMD_PUSH_BACK) ? fill : 0, req.value);
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (fill == 0)
                        res.status = ST_EMPTY;
                    else
                        res.read_value = close_gap((req.command == CMD_POP_FRONT) ? 0 : fill - 1);
                end
                CMD_GET:
                begin
                    if (req.position >= fill)
                        res.status = ST_OOB;
                    else
                        res.read_value = slots[req.position];
                end
                CMD_SET:
                begin
                    if (req.position >= fill)
                        res.status = ST_OOB;
                    else
                        slots[req.position] = req.value;
                end
                CMD_INSERT:
                begin
                    // The index is checked before the list is found full.
                    if (req.position > fill)
                        res.status = ST_OOB;
                    else if (fill >= DEPTH)
                        res.status = ST_FULL;
                    else
                        open_gap(req.position, req.value);
                end
                CMD_REMOVE:
                begin
                    if (req.position >= fill)
                        res.status = ST_OOB;
                    else
                        void'(close_gap(req.position));
                end
                CMD_CLEAR:
                    fill = 0;
                default:
                    ;
            endcase
            // The recorded error is only ever overwritten by a newer one.
            if (res.status != ST_OK)
                last_error = res.status;
            res.occupancy  = 5'(fill);
            res.is_empty   = (fill == 0);
            res.error_seen = (last_error != ST_OK);
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0)
            begin
                $error("result arrived with no request outstanding: %p", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            compare_field("error_seen", 32'(want.error_seen), 32'(got.error_seen));
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    list_shadow  shadow;
    bit          steady = 1'b0;
    int unsigned stalled = 0;

    indexed_list_store i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic send_request(logic [3:0] cmd, logic [4:0] pos, logic [31:0] word);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{command: cmd, position: pos, value: word};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // The shadow fill may trail the block by one request; it only steers the indexes.
    task automatic send_random(int trend);
        logic [3:0]  cmd;
        logic [4:0]  pos;
        logic [31:0] word;
        int unsigned r;
        int unsigned fill;
        fill = shadow.fill;
        r = $urandom_range(0, 99);
        if (r < 4)
            cmd = 4'($urandom_range(9, 15));
        else if (r < 6 && trend != TREND_GROW)
            cmd = CMD_CLEAR;
        else if (r < 50 && trend == TREND_GROW)
        begin
            case ($urandom_range(0, 2))
                0: cmd = CMD_PUSH_BACK;
                1: cmd = CMD_PUSH_FRONT;
                default: cmd = CMD_INSERT;
            endcase
        end
        else if (r < 50 && trend == TREND_SHRINK)
        begin
            case ($urandom_range(0, 2))
                0: cmd = CMD_POP_FRONT;
                1: cmd = CMD_POP_BACK;
                default: cmd = CMD_REMOVE;
            endcase
        end
        else
            cmd = 4'($urandom_range(0, 7));

        if ($urandom_range(0, 9) == 0)
            pos = 5'($urandom_range(0, 31));
        else if (cmd == CMD_INSERT)
            pos = 5'($urandom_range(0, fill));
        else
            pos = 5'($urandom_range(0, (fill == 0) ? 0 : fill - 1));

        r = $urandom_range(0, 9);
        if (r == 0)
            word = 32'h0000_0000;
        else if (r == 1)
            word = 32'hFFFF_FFFF;
        else
            word = $urandom;
        send_request(cmd, pos, word);
    endtask

    // Request and result monitor, plus the watchdog on cycles with no progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                shadow.apply_request(in_item);
            if (out_valid && out_ready)
                shadow.check_result(out_item);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else if (stalled >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                stalled++;
        end
    end

    initial
    begin
        int unsigned hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = pick_gap();
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        int trend;
        int unsigned k;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        trend    = TREND_MIXED;
        shadow   = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: pops fail, indexes fail, insert only at the head.
        send_request(CMD_POP_FRONT, 5'd0, 32'h0000_0000);
        send_request(CMD_POP_BACK, 5'd31, 32'hFFFF_FFFF);
        send_request(CMD_GET, 5'd0, 32'h0000_0000);
        send_request(CMD_INSERT, 5'd1, 32'h1234_5678);
        send_request(CMD_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_request(CMD_PUSH_FRONT, 5'd0, 32'h0000_0000);
        for (k = 0; k < DEPTH - 2; k++)
            send_request(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, 5'(k), $urandom);

        // Full list: pushes and an in-range insert are refused.
        send_request(CMD_PUSH_BACK, 5'd0, 32'hA5A5_A5A5);
        send_request(CMD_PUSH_FRONT, 5'd0, 32'h5A5A_5A5A);
        send_request(CMD_INSERT, 5'd16, 32'h0F0F_0F0F);
        send_request(CMD_INSERT, 5'd17, 32'hF0F0_F0F0);
        send_request(CMD_SET, 5'd15, 32'hFFFF_FFFF);
        send_request(CMD_GET, 5'd15, 32'h0000_0000);
        send_request(CMD_REMOVE, 5'd7, 32'h0000_0000);
        send_request(CMD_POP_FRONT, 5'd0, 32'h0000_0000);
        send_request(CMD_POP_BACK, 5'd0, 32'h0000_0000);
        send_request(4'hF, 5'd31, 32'hFFFF_FFFF);
        send_request(CMD_CLEAR, 5'd0, 32'h0000_0000);
        send_request(CMD_POP_BACK, 5'd0, 32'h0000_0000);

        for (int unsigned n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 50 == 0)
            begin
                trend  = $urandom_range(TREND_MIXED, TREND_SHRINK);
                steady = ($urandom_range(0, 3) == 0);
            end
            send_random(trend);
        end
        in_valid <= 1'b0;

        // Let the monitor note the last request before waiting on the queue.
        @(posedge clk);
        while (shadow.expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (shadow.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
